// ===== rtl/rfcf_pkg.sv =====
// Shared types, constants and CRC-8 helper for the radio command packet framer.
`default_nettype none

package rfcf_pkg;

    localparam logic [7:0] CRC_POLY = 8'h8D;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Byte positions inside one packet
    localparam int unsigned PKT_LEN = 7;
    localparam int unsigned IDX_W   = $clog2(PKT_LEN);

    typedef logic [IDX_W-1:0] byte_idx_t;

    localparam byte_idx_t IDX_CMD3 = byte_idx_t'(0);
    localparam byte_idx_t IDX_CMD2 = byte_idx_t'(1);
    localparam byte_idx_t IDX_CMD1 = byte_idx_t'(2);
    localparam byte_idx_t IDX_CMD0 = byte_idx_t'(3);
    localparam byte_idx_t IDX_CHN1 = byte_idx_t'(4);
    localparam byte_idx_t IDX_CHN0 = byte_idx_t'(5);
    localparam byte_idx_t IDX_CRC  = byte_idx_t'(PKT_LEN - 1);

    typedef struct packed {
        logic [31:0] cmd;
        logic [15:0] chan;
        logic [7:0]  crc;
    } frame_t;

    // One byte of CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (r[7])
            begin
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rf_command_packet_framer_crc8_unit.sv =====
// Top level of the radio command packet framer with CRC-8 (poly 0x8D, init 0xFF).
// Usage:
//   Input channel (in_valid/in_ready, command_word): one request carries one
//   32-bit command. Output channel (out_valid/out_ready, packet_byte,
//   last_byte): each command yields seven byte requests in transmit order:
//   command MSB first, channel MSB first, then the CRC byte with last_byte set.
//   Configuration channel (cfg_valid/cfg_ready, radio_channel): always ready;
//   write only while no packet is in flight. The channel is sampled when a
//   command enters.
// Timing:
//   Three CRC stages fold two bytes each, then a serializer sends the bytes.
//   The first byte of a packet is presented once its command has passed
//   stages 0, 1 and 2 and been loaded into the serializer; the remaining six
//   follow one per cycle while out_ready is high. Sustained throughput is
//   set by the serializer's one-byte-per-cycle output port. Up to three more
//   commands queue in the CRC stages while a packet drains.
// Reset clears all valid bits and the channel register (channel 0).
// When out_ready drops, the current byte holds and the stages fill, then
// in_ready falls; nothing is dropped or repeated.
`default_nettype none

module rf_command_packet_framer_crc8_unit
    import rfcf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] radio_channel,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] command_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       packet_byte,
    output logic             last_byte
);

    logic [15:0] chan_reg, chan_next;

    frame_t s0_in, s0_frame, s1_frame, s2_frame;
    logic   s0_valid, s1_valid, s2_valid;
    logic   s1_ready, s2_ready, ser_ready;

    // Configuration register: always accept the write
    assign cfg_ready = 1'b1;

    always_comb
    begin
        chan_next = chan_reg;
        if (cfg_valid && cfg_ready)
        begin
            chan_next = radio_channel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= 16'h0000;
        end
        else
        begin
            chan_reg <= chan_next;
        end
    end

    // Seed the frame with the command, the current channel and the CRC start value
    always_comb
    begin
        s0_in.cmd  = command_word;
        s0_in.chan = chan_reg;
        s0_in.crc  = CRC_INIT;
    end

    // Stage 0: command bytes 3 and 2
    rfcf_crc_stage u_stage0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_frame  (s0_in),
        .in_byte_a (command_word[31:24]),
        .in_byte_b (command_word[23:16]),
        .out_valid (s0_valid),
        .out_ready (s1_ready),
        .out_frame (s0_frame)
    );

    // Stage 1: command bytes 1 and 0
    rfcf_crc_stage u_stage1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid),
        .in_ready  (s1_ready),
        .in_frame  (s0_frame),
        .in_byte_a (s0_frame.cmd[15:8]),
        .in_byte_b (s0_frame.cmd[7:0]),
        .out_valid (s1_valid),
        .out_ready (s2_ready),
        .out_frame (s1_frame)
    );

    // Stage 2: channel high and low bytes
    rfcf_crc_stage u_stage2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s2_ready),
        .in_frame  (s1_frame),
        .in_byte_a (s1_frame.chan[15:8]),
        .in_byte_b (s1_frame.chan[7:0]),
        .out_valid (s2_valid),
        .out_ready (ser_ready),
        .out_frame (s2_frame)
    );

    // Drain each finished frame one byte per request
    rfcf_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (ser_ready),
        .in_frame  (s2_frame),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (packet_byte),
        .out_last  (last_byte)
    );

    // An accepted command always lands in the first stage
    a_enter_s0: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s0_valid)
        else $error("accepted command missing from stage 0");

    // A packet is never cut short: after a non-final byte, another byte follows
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_byte) |=> out_valid)
        else $error("packet truncated after non-final byte");

    // A finished frame waiting at the serializer is taken as the current packet's last byte goes
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_byte && s2_valid) |=> (out_valid && !last_byte))
        else $error("queued frame not loaded after packet end");

endmodule

`default_nettype wire

// ===== rtl/rfcf_crc_stage.sv =====
// One elastic pipeline stage that folds two packet bytes into the running CRC.
`default_nettype none

module rfcf_crc_stage
    import rfcf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire frame_t in_frame,
    input  wire logic [7:0] in_byte_a,
    input  wire logic [7:0] in_byte_b,
    output logic        out_valid,
    input  wire logic   out_ready,
    output frame_t      out_frame
);

    logic   valid_reg, valid_next;
    frame_t frame_reg, frame_next;
    logic   load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        frame_next = frame_reg;
        if (load)
        begin
            frame_next.cmd  = in_frame.cmd;
            frame_next.chan = in_frame.chan;
            frame_next.crc  = crc8_byte(crc8_byte(in_frame.crc, in_byte_a), in_byte_b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds without reset
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign out_valid = valid_reg;
    assign out_frame = frame_reg;

endmodule

`default_nettype wire

// ===== rtl/rfcf_serializer.sv =====
// Packet serializer: sends a finished frame one byte per request.
`default_nettype none

module rfcf_serializer
    import rfcf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire frame_t in_frame,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last
);

    logic      busy_reg, busy_next;
    byte_idx_t idx_reg, idx_next;
    frame_t    frame_reg, frame_next;
    logic      send, load, at_last;

    assign at_last  = (idx_reg == IDX_CRC);
    assign send     = busy_reg && out_ready;
    assign in_ready = !busy_reg || (out_ready && at_last);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        frame_next = frame_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            idx_next   = IDX_CMD3;
            frame_next = in_frame;
        end
        else if (send)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + byte_idx_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= IDX_CMD3;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    always_comb
    begin
        unique case (idx_reg)
            IDX_CMD3: out_byte = frame_reg.cmd[31:24];
            IDX_CMD2: out_byte = frame_reg.cmd[23:16];
            IDX_CMD1: out_byte = frame_reg.cmd[15:8];
            IDX_CMD0: out_byte = frame_reg.cmd[7:0];
            IDX_CHN1: out_byte = frame_reg.chan[15:8];
            IDX_CHN0: out_byte = frame_reg.chan[7:0];
            IDX_CRC:  out_byte = frame_reg.crc;
            default:  out_byte = 8'h00;
        endcase
    end

    assign out_valid = busy_reg;
    assign out_last  = at_last;

endmodule

`default_nettype wire

// ===== tb/sv/tb_rf_command_packet_framer_crc8_unit.sv =====
// Self-checking testbench for the radio command packet framer with CRC-8.
`default_nettype none

module tb_rf_command_packet_framer_crc8_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // CRC-8 parameters of the radio packet: MSB first, no reflection, no final XOR
    localparam logic [7:0] CRC8_POLY  = 8'h8D;
    localparam logic [7:0] CRC8_SEED  = 8'hFF;
    localparam int         HEAD_BYTES = 6;

    // Run control
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 12;     // wait for stray bytes after the drain
    localparam int LONG_HOLD    = 400;    // receiver hold-off that backs the block up
    localparam int PHASE_ITEMS  = 24;
    localparam int PHASE_COUNT  = 8;
    localparam int DIRECTED_ROWS = 21;

    // One expected output request: a packet byte and its end-of-packet flag
    typedef struct {
        logic [7:0] data;
        logic       last;
    } due_byte_t;

    // Directed stimulus: either a command request or a channel write
    typedef enum logic {ROW_CMD, ROW_CHANNEL} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [31:0] value;
        logic        known;   // header bytes typed in below
        logic [47:0] head;    // bytes 0..5 in transmit order
    } stim_row_t;

    // The channel register resets to 0, so the first rows have a plain
    // header: command MSB first, then two zero bytes. Only the CRC byte
    // of those rows comes from the predictor.
    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{ROW_CMD,     32'h0000_0000, 1'b1, 48'h0000_0000_0000},
        '{ROW_CMD,     32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_0000},
        '{ROW_CMD,     32'h8000_0000, 1'b1, 48'h8000_0000_0000},
        '{ROW_CMD,     32'h0000_0001, 1'b1, 48'h0000_0001_0000},
        '{ROW_CMD,     32'h1234_5678, 1'b1, 48'h1234_5678_0000},
        '{ROW_CMD,     32'hA5A5_A5A5, 1'b0, 48'h0},
        '{ROW_CMD,     32'h5A5A_5A5A, 1'b0, 48'h0},
        '{ROW_CMD,     32'h0000_00FF, 1'b0, 48'h0},
        '{ROW_CHANNEL, 32'h0000_FFFF, 1'b0, 48'h0},
        '{ROW_CMD,     32'h0000_0000, 1'b1, 48'h0000_0000_FFFF},
        '{ROW_CMD,     32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF},
        '{ROW_CMD,     32'hDEAD_BEEF, 1'b0, 48'h0},
        '{ROW_CHANNEL, 32'h0000_8000, 1'b0, 48'h0},
        '{ROW_CMD,     32'h0102_0304, 1'b1, 48'h0102_0304_8000},
        '{ROW_CMD,     32'h7FFF_FFFF, 1'b0, 48'h0},
        '{ROW_CHANNEL, 32'h0000_0001, 1'b0, 48'h0},
        '{ROW_CMD,     32'h0000_0000, 1'b1, 48'h0000_0000_0001},
        '{ROW_CMD,     32'hC3C3_C3C3, 1'b0, 48'h0},
        '{ROW_CHANNEL, 32'h0000_00FF, 1'b0, 48'h0},
        '{ROW_CMD,     32'hFF00_FF00, 1'b0, 48'h0},
        '{ROW_CMD,     32'h00FF_00FF, 1'b0, 48'h0}
    };

    // DUT signals; every input has a known value from time zero
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] radio_channel = 16'h0000;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [31:0] command_word  = 32'h0000_0000;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [7:0]  packet_byte;
    logic        last_byte;

    // Predictor state and the store of bytes still to come
    logic [15:0] channel_shadow = 16'h0000;
    due_byte_t   bytes_due [$];

    // Idle control for the sender and the receiver, and the error and cycle counters
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int long_holds_asked = 0;
    int error_count = 0;
    int cycle_count = 0;

    rf_command_packet_framer_crc8_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .radio_channel (radio_channel),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command_word  (command_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .packet_byte   (packet_byte),
        .last_byte     (last_byte)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Fold one byte into the CRC, one bit at a time: feedback is the top CRC
    // bit XOR the incoming data bit, and a set feedback applies the polynomial.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        logic       feedback;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            feedback = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0} ^ (feedback ? CRC8_POLY : 8'h00);
        end
        return acc;
    endfunction

    // CRC over the six header bytes, first byte in the top bits
    function automatic logic [7:0] header_crc(input logic [47:0] head);
        logic [7:0] crc;
        crc = CRC8_SEED;
        for (int k = 0; k < HEAD_BYTES; k++)
        begin
            crc = crc8_fold(crc, head[47 - 8*k -: 8]);
        end
        return crc;
    endfunction

    // Queue the seven bytes a command produces; a typed header overrides the
    // predicted one, the CRC is always predicted from the live channel.
    function automatic void frame_command(input logic [31:0] cmd, input logic known,
                                          input logic [47:0] typed_head);
        logic [47:0] head;
        due_byte_t   entry;
        head = {cmd, channel_shadow};
        for (int k = 0; k < HEAD_BYTES; k++)
        begin
            entry.data = known ? typed_head[47 - 8*k -: 8] : head[47 - 8*k -: 8];
            entry.last = 1'b0;
            bytes_due.push_back(entry);
        end
        entry.data = header_crc(head);
        entry.last = 1'b1;
        bytes_due.push_back(entry);
    endfunction

    function automatic logic [31:0] pick_command();
        logic [31:0] cmd;
        case ($urandom_range(7))
            0: cmd = 32'h0000_0000;
            1: cmd = 32'hFFFF_FFFF;
            2: cmd = 32'h0000_0001 << $urandom_range(31);
            3: cmd = ~(32'h0000_0001 << $urandom_range(31));
            default: cmd = $urandom();
        endcase
        return cmd;
    endfunction

    function automatic logic [15:0] pick_channel();
        logic [15:0] chan;
        case ($urandom_range(5))
            0: chan = 16'h0000;
            1: chan = 16'hFFFF;
            default: chan = 16'($urandom_range(65535));
        endcase
        return chan;
    endfunction

    // Offer one command request. Valid from the previous request stays high
    // unless a gap is rolled, so back-to-back requests never toggle it.
    task automatic send_command(input logic [31:0] cmd, input logic known,
                                input logic [47:0] typed_head);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command_word <= cmd;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        frame_command(cmd, known, typed_head);
    endtask

    // Write the channel once no packet is in flight. Drop the command valid
    // first so the last command is not taken twice while the block drains.
    task automatic write_channel(input logic [15:0] chan);
        in_valid <= 1'b0;
        while (bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_valid     <= 1'b1;
        radio_channel <= chan;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        channel_shadow = chan;
        cfg_valid <= 1'b0;
    endtask

    // Receiver: check each accepted byte against the oldest expectation, then
    // pick out_ready for the next cycle. A long hold-off is counted here.
    initial
    begin : receiver
        int holds_done;
        int hold_left;
        due_byte_t want;
        holds_done = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready)
            begin
                if (bytes_due.size() == 0)
                begin
                    $error("packet_byte: no byte expected, got %h (last_byte %b)",
                           packet_byte, last_byte);
                    error_count++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (packet_byte !== want.data)
                    begin
                        $error("packet_byte: expected %h, got %h", want.data, packet_byte);
                        error_count++;
                    end
                    if (last_byte !== want.last)
                    begin
                        $error("last_byte: expected %b, got %b", want.last, last_byte);
                        error_count++;
                    end
                end
            end
            if (holds_done != long_holds_asked)
            begin
                holds_done = long_holds_asked;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run with a mismatch once the cycle limit is passed
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("rf_command_packet_framer_crc8_unit: mismatch");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, then randomized phases
    initial
    begin : stimulus
        int idle_pairs [4][2];
        idle_pairs = '{'{0, 0}, '{83, 0}, '{0, 83}, '{26, 26}};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs without idling so commands queue back to back
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CHANNEL)
            begin
                write_channel(directed_rows[i].value[15:0]);
            end
            else
            begin
                send_command(directed_rows[i].value, directed_rows[i].known,
                             directed_rows[i].head);
            end
        end

        // Random phases; each starts idle with a fresh channel
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_channel(pick_channel());
            send_idle_pct  = idle_pairs[p % 4][0];
            recv_stall_pct = idle_pairs[p % 4][1];
            // Hold the receiver off while the sender keeps pushing, so the
            // CRC stages fill and in_ready falls
            if (p == 4)
            begin
                long_holds_asked++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_command(pick_command(), 1'b0, 48'h0);
            end
        end

        // Drain: wait for every byte, then watch for strays
        in_valid <= 1'b0;
        while (bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("rf_command_packet_framer_crc8_unit: match");
        end
        else
        begin
            $display("rf_command_packet_framer_crc8_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
